### hw/rtl/bgc_pkg.sv
package bgc_pkg;

    localparam int MAX_WIDTH       = 2048;
    localparam int MAX_WINDOW      = 128;
    localparam int ANGLE_FRAC_BITS = 14;

    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int SUM_W   = 40;
    localparam int CNT_W   = 15;
    localparam int GRAD_W  = 13;
    localparam int PROD_W  = 2 * GRAD_W;
    localparam int ENTRY_W = 3 * SUM_W + CNT_W;

    // Serial multiplier and CORDIC datapath widths.
    localparam int ACC_W = 97;
    localparam int MUL_W = 41;
    localparam int CRD_W = 45;
    localparam int ANG_W = 35;
    localparam int ORI_W = 16;
    localparam int CORDIC_STEPS = 31;

    localparam logic [ANG_W-1:0] PI_Q30    = 35'd3373259426;
    localparam logic [MUL_W-1:0] COH_SCALE = 41'd10000;

    localparam logic [1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_WINDOW     = 2'd1;
    localparam logic [1:0] CFG_EDGE_THR   = 2'd2;
    localparam logic [1:0] CFG_COH_THR    = 2'd3;

    typedef struct packed {
        logic [11:0] line_width;
        logic [7:0]  win_size;
        logic [24:0] edge_threshold_sq;
        logic [13:0] coherence_threshold;
    } cfg_t;

    typedef struct packed {
        logic [SUM_W-1:0] xx;
        logic [SUM_W-1:0] yy;
        logic [SUM_W-1:0] xy;
        logic [CNT_W-1:0] edges;
    } entry_t;

    typedef struct packed {
        logic [10:0]      bx;
        logic [10:0]      by;
        logic [SUM_W-1:0] a;
        logic [SUM_W-1:0] b;
        logic [SUM_W-1:0] c;
        logic [CNT_W-1:0] edges;
    } blk_item_t;

    function automatic logic [11:0] eff_width(input logic [11:0] lw);
        logic [11:0] r;
        if (lw == 12'd0) r = 12'd1;
        else if (lw > 12'(MAX_WIDTH)) r = 12'(MAX_WIDTH);
        else r = lw;
        return r;
    endfunction

    function automatic logic [7:0] eff_window(input logic [7:0] ws);
        logic [7:0] r;
        if (ws == 8'd0) r = 8'd1;
        else if (ws > 8'(MAX_WINDOW)) r = 8'(MAX_WINDOW);
        else r = ws;
        return r;
    endfunction

    // Arctangent of 2^-i in Q30 radians, truncated.
    function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] i);
        logic [ANG_W-1:0] one;
        logic [ANG_W-1:0] r;
        one = ANG_W'(1);
        case (i)
            5'd0:    r = 35'h03243F6A8;
            5'd1:    r = 35'h01DAC6705;
            5'd2:    r = 35'h00FADBAFC;
            5'd3:    r = 35'h007F56EA6;
            5'd4:    r = 35'h003FEAB76;
            5'd5:    r = 35'h001FFD55B;
            5'd6:    r = 35'h000FFFAAA;
            5'd7:    r = 35'h0007FFF55;
            5'd8:    r = 35'h0003FFFEA;
            5'd9:    r = 35'h0001FFFFD;
            default: r = (one << (5'd30 - i)) - one;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/bgc_ram.sv
module bgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

### hw/rtl/bgc_front.sv
module bgc_front import bgc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic [31:0] s_tdata,
    input  logic      s_tuser,
    output blk_item_t push_item,
    output logic      push_valid,
    input  logic      push_ready
);

    typedef enum logic [2:0] {
        FS_IDLE = 3'b001,
        FS_RD   = 3'b010,
        FS_WR   = 3'b100
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [10:0] col_reg, row_reg, bcol_reg, brow_reg;
    logic [6:0]  cib_reg, rib_reg;
    logic [10:0] col_e, row_e, bcol_e, brow_e;
    logic [6:0]  cib_e, rib_e;

    logic [ADDR_W-1:0] k_reg;
    logic [10:0]       by_reg;
    logic              first_reg, last_reg;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic              pe_reg;
    logic [PROD_W-1:0] pxx_reg, pyy_reg;
    logic signed [PROD_W-1:0] pxy_reg;

    logic [11:0] wl;
    logic [7:0]  ws;
    logic        accept, advance;
    logic        col_wrap, cib_wrap, rib_wrap;

    logic signed [PROD_W-1:0] sqx, sqy, sxy;
    logic [PROD_W-1:0]        mag;

    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             old_e, new_e;
    logic [SUM_W-1:0]   ext_xx, ext_yy, ext_xy;
    logic [ADDR_W-1:0]  ram_addr;

    assign wl       = eff_width(cfg.line_width);
    assign ws       = eff_window(cfg.win_size);
    assign s_tready = (state_reg == FS_IDLE);
    assign accept   = s_tvalid && s_tready;

    // A frame start restarts every position counter before this pixel.
    assign col_e  = s_tuser ? 11'd0 : col_reg;
    assign row_e  = s_tuser ? 11'd0 : row_reg;
    assign bcol_e = s_tuser ? 11'd0 : bcol_reg;
    assign brow_e = s_tuser ? 11'd0 : brow_reg;
    assign cib_e  = s_tuser ? 7'd0 : cib_reg;
    assign rib_e  = s_tuser ? 7'd0 : rib_reg;

    assign col_wrap = ({1'b0, col_e} + 12'd1) >= wl;
    assign cib_wrap = ({1'b0, cib_e} + 8'd1) >= ws;
    assign rib_wrap = ({1'b0, rib_e} + 8'd1) >= ws;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            bcol_reg <= '0;
            brow_reg <= '0;
            cib_reg  <= '0;
            rib_reg  <= '0;
        end else if (accept) begin
            if (col_wrap) begin
                col_reg  <= '0;
                cib_reg  <= '0;
                bcol_reg <= '0;
                row_reg  <= row_e + 11'd1;
                if (rib_wrap) begin
                    rib_reg  <= '0;
                    brow_reg <= brow_e + 11'd1;
                end else begin
                    rib_reg  <= rib_e + 7'd1;
                    brow_reg <= brow_e;
                end
            end else begin
                col_reg  <= col_e + 11'd1;
                row_reg  <= row_e;
                rib_reg  <= rib_e;
                brow_reg <= brow_e;
                if (cib_wrap) begin
                    cib_reg  <= '0;
                    bcol_reg <= bcol_e + 11'd1;
                end else begin
                    cib_reg  <= cib_e + 7'd1;
                    bcol_reg <= bcol_e;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            k_reg     <= bcol_e;
            by_reg    <= brow_e;
            first_reg <= (rib_e == 7'd0) && (cib_e == 7'd0);
            last_reg  <= ({1'b0, cib_e} == ws - 8'd1) && ({1'b0, rib_e} == ws - 8'd1);
            gx_reg    <= $signed(s_tdata[12:0]);
            gy_reg    <= $signed(s_tdata[25:13]);
        end
    end

    // Folding an edge to gx >= 0 negates both gradients, which leaves all
    // three products unchanged.
    assign sqx = gx_reg * gx_reg;
    assign sqy = gy_reg * gy_reg;
    assign sxy = gx_reg * gy_reg;
    assign mag = $unsigned(sqx) + $unsigned(sqy);

    always_ff @(posedge aclk) begin
        if (state_reg == FS_RD) begin
            pe_reg  <= mag > {1'b0, cfg.edge_threshold_sq};
            pxx_reg <= $unsigned(sqx);
            pyy_reg <= $unsigned(sqy);
            pxy_reg <= sxy;
        end
    end

    assign old_e  = entry_t'(ram_rdata);
    assign ext_xx = pe_reg ? SUM_W'(pxx_reg) : '0;
    assign ext_yy = pe_reg ? SUM_W'(pyy_reg) : '0;
    assign ext_xy = pe_reg ? SUM_W'(pxy_reg) : '0;

    always_comb begin
        if (first_reg) begin
            new_e.xx    = ext_xx;
            new_e.yy    = ext_yy;
            new_e.xy    = ext_xy;
            new_e.edges = CNT_W'(pe_reg);
        end else begin
            new_e.xx    = old_e.xx + ext_xx;
            new_e.yy    = old_e.yy + ext_yy;
            new_e.xy    = old_e.xy + ext_xy;
            new_e.edges = old_e.edges + CNT_W'(pe_reg);
        end
    end

    assign push_valid = (state_reg == FS_WR) && last_reg;
    assign advance    = (state_reg == FS_WR) && (!last_reg || push_ready);

    assign push_item.bx    = k_reg;
    assign push_item.by    = by_reg;
    assign push_item.a     = new_e.xx;
    assign push_item.b     = new_e.yy;
    assign push_item.c     = new_e.xy;
    assign push_item.edges = new_e.edges;

    assign ram_addr = (state_reg == FS_WR) ? k_reg : bcol_e;

    bgc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_buf (
        .aclk  (aclk),
        .we    (advance),
        .re    (accept),
        .addr  (ram_addr),
        .wdata (ENTRY_W'(new_e)),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE: begin
                if (accept) state_next = FS_RD;
            end
            FS_RD: begin
                state_next = FS_WR;
            end
            FS_WR: begin
                if (advance) state_next = FS_IDLE;
            end
            default: state_next = FS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/bgc_queue.sv
module bgc_queue import bgc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  blk_item_t push_item,
    input  logic      push_valid,
    output logic      push_ready,
    output blk_item_t pop_item,
    output logic      pop_valid,
    input  logic      pop_ready
);

    blk_item_t  slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop) rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop) cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push) cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

### hw/rtl/bgc_back.sv
module bgc_back import bgc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  blk_item_t   pop_item,
    input  logic        pop_valid,
    output logic        pop_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SQD  = 9'b000000010,
        ST_SQC  = 9'b000000100,
        ST_SCL  = 9'b000001000,
        ST_SQS  = 9'b000010000,
        ST_SCR  = 9'b000100000,
        ST_TEST = 9'b001000000,
        ST_CORD = 9'b010000000,
        ST_OUT  = 9'b100000000
    } bstate_t;

    bstate_t state_reg, state_next;

    blk_item_t item_reg, item_next;
    logic signed [MUL_W-1:0] d_reg, d_next;
    logic [ACC_W-1:0] acc_reg, acc_next, mcand_reg, mcand_next, lhs_reg, lhs_next;
    logic [MUL_W-1:0] mplier_reg, mplier_next;
    logic signed [CRD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    logic [4:0] iter_reg, iter_next;
    logic       coh_reg, coh_next;
    logic [ORI_W-1:0] ori_reg, ori_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [55:0] m_tdata_reg, m_tdata_next;

    // Combinational helpers.
    logic signed [MUL_W-1:0] d_in;
    logic [SUM_W-1:0] ad_in, cabs;
    logic [MUL_W-1:0] ac2, s_ab;
    logic [ACC_W-1:0] acc_step;
    logic             mul_done;
    logic [7:0]       ws;
    logic [15:0]      wsq;
    logic             aniso, dense;
    logic signed [CRD_W-1:0] x0, y0, xs, ys, xc, yc;
    logic signed [ANG_W-1:0] at, zc, z_rnd;
    logic [ORI_W-1:0] ori_fin;
    logic             out_load;

    assign ws  = eff_window(cfg.win_size);
    assign wsq = {8'd0, ws} * {8'd0, ws};

    assign d_in  = $signed({1'b0, pop_item.a}) - $signed({1'b0, pop_item.b});
    assign ad_in = d_in[MUL_W-1] ? SUM_W'(-d_in) : SUM_W'(d_in);
    assign cabs  = item_reg.c[SUM_W-1] ? (~item_reg.c + SUM_W'(1)) : item_reg.c;
    assign ac2   = {cabs, 1'b0};
    assign s_ab  = {1'b0, item_reg.a} + {1'b0, item_reg.b};

    assign mul_done = (mplier_reg == '0);
    assign acc_step = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    assign aniso = lhs_reg > acc_reg;
    assign dense = {item_reg.edges, 1'b0} >= wsq;

    assign x0 = CRD_W'($signed({item_reg.c, 1'b0}));
    assign y0 = CRD_W'(d_reg);

    assign xs = x_reg >>> iter_reg;
    assign ys = y_reg >>> iter_reg;
    assign at = $signed(atan_entry(iter_reg));

    always_comb begin
        if (y_reg > 0) begin
            xc = x_reg + ys;
            yc = y_reg - xs;
            zc = z_reg + at;
        end else begin
            xc = x_reg - ys;
            yc = y_reg + xs;
            zc = z_reg - at;
        end
    end

    assign z_rnd   = zc + (ANG_W'(1) << (30 - ANGLE_FRAC_BITS));
    assign ori_fin = ORI_W'(z_rnd >>> (31 - ANGLE_FRAC_BITS));

    assign pop_ready = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next  = state_reg;
        item_next   = item_reg;
        d_next      = d_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        lhs_next    = lhs_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        iter_next   = iter_reg;
        coh_next    = coh_reg;
        ori_next    = ori_reg;

        if ((state_reg == ST_SQD || state_reg == ST_SQC || state_reg == ST_SCL ||
             state_reg == ST_SQS || state_reg == ST_SCR) && !mul_done) begin
            acc_next    = acc_step;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    item_next   = pop_item;
                    d_next      = d_in;
                    acc_next    = '0;
                    mcand_next  = ACC_W'(ad_in);
                    mplier_next = MUL_W'(ad_in);
                    state_next  = ST_SQD;
                end
            end
            ST_SQD: begin
                if (mul_done) begin
                    mcand_next  = ACC_W'(ac2);
                    mplier_next = ac2;
                    state_next  = ST_SQC;
                end
            end
            ST_SQC: begin
                if (mul_done) begin
                    acc_next    = '0;
                    mcand_next  = acc_reg;
                    mplier_next = COH_SCALE;
                    state_next  = ST_SCL;
                end
            end
            ST_SCL: begin
                if (mul_done) begin
                    lhs_next    = acc_reg;
                    acc_next    = '0;
                    mcand_next  = ACC_W'(s_ab);
                    mplier_next = s_ab;
                    state_next  = ST_SQS;
                end
            end
            ST_SQS: begin
                if (mul_done) begin
                    acc_next    = '0;
                    mcand_next  = acc_reg;
                    mplier_next = MUL_W'(cfg.coherence_threshold);
                    state_next  = ST_SCR;
                end
            end
            ST_SCR: begin
                if (mul_done) state_next = ST_TEST;
            end
            ST_TEST: begin
                coh_next  = aniso && dense;
                ori_next  = '0;
                iter_next = '0;
                if (!(aniso && dense) || (x0 == 0 && y0 == 0)) begin
                    state_next = ST_OUT;
                end else begin
                    // A negative x is first turned by half a circle.
                    if (x0 < 0) begin
                        x_next = -x0;
                        y_next = -y0;
                        z_next = (y0 >= 0) ? $signed(PI_Q30) : -$signed(PI_Q30);
                    end else begin
                        x_next = x0;
                        y_next = y0;
                        z_next = '0;
                    end
                    state_next = ST_CORD;
                end
            end
            ST_CORD: begin
                x_next    = xc;
                y_next    = yc;
                z_next    = zc;
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(CORDIC_STEPS - 1)) begin
                    ori_next   = ori_fin;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register: m_tdata is block_x, block_y, coherent, orientation,
    // edge_count from bit 0 up.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, item_reg.edges, ori_reg, coh_reg, item_reg.by, item_reg.bx};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        d_reg       <= d_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        lhs_reg     <= lhs_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        iter_reg    <= iter_next;
        coh_reg     <= coh_next;
        ori_reg     <= ori_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_noncoh_zero_ori: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[22]) |-> (m_tdata[38:23] == '0))
        else $error("non-coherent block carries an orientation");
    a_cordic_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORD) |-> (iter_reg <= 5'(CORDIC_STEPS - 1)))
        else $error("CORDIC iteration count out of range");
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid_reg)
        else $error("loaded result not presented");
`endif

endmodule

### hw/rtl/block_gradient_coherence_core.sv
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid/s_tready    s_tdata gx, gy; s_tuser frame_start
// m_       out        m_tvalid/m_tready    m_tdata block result
// cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each pixel is handled in the front end by a read, update and write back of
// its block column's entry in the single-port row buffer; no new pixel is taken until the write.
// In the back end, the time for each completed block is set by the bit lengths of
// its sums; bit-serial multiplies form the terms and a coherent block adds 31 CORDIC steps.
// A two-entry queue separates the two ends; the front stalls when it is full.
// Reset is synchronous; the row buffer has no reset and no clearing pass.
module block_gradient_coherence_core import bgc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // gx[12:0], gy[25:13], zero fill
    input  logic        s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // block_x, block_y, coherent, orientation, edge_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [24:0] cfg_data
);

    cfg_t      cfg_reg;
    blk_item_t push_item, pop_item;
    logic      push_valid, push_ready, pop_valid, pop_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_width          <= 12'd1024;
            cfg_reg.win_size            <= 8'd10;
            cfg_reg.edge_threshold_sq   <= 25'd2304;
            cfg_reg.coherence_threshold <= 14'd7225;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LINE_WIDTH: cfg_reg.line_width          <= cfg_data[11:0];
                CFG_WINDOW:     cfg_reg.win_size            <= cfg_data[7:0];
                CFG_EDGE_THR:   cfg_reg.edge_threshold_sq   <= cfg_data;
                CFG_COH_THR:    cfg_reg.coherence_threshold <= cfg_data[13:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    bgc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    bgc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    bgc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_item  (pop_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
